// File: rtl/wsdb_pkg.sv
// ----------------------------------------------------------------------------
// wsdb_pkg
// Shared types and constants of the work-stealing deque bank.
// ----------------------------------------------------------------------------
package wsdb_pkg;

  localparam int TASK_BITS    = 32;
  localparam int QUEUES_DEF   = 8;
  localparam int DEPTH_DEF    = 64;
  localparam int WORKER_BITS  = 3;
  localparam int CFG_BITS     = 4;
  localparam int ACTIVE_RESET = 8;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_OWN    = 3'd1,
    ST_STOLEN = 3'd2,
    ST_NONE   = 3'd3,
    ST_FULL   = 3'd4,
    ST_BAD    = 3'd5
  } status_t;

  typedef struct packed {
    logic                   opcode;
    logic [WORKER_BITS-1:0] worker;
    logic [TASK_BITS-1:0]   task_word;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [TASK_BITS-1:0]   task_out;
    logic [WORKER_BITS-1:0] source_queue;
  } rsp_t;

endpackage

// File: rtl/wsdb_task_ram.sv
// ----------------------------------------------------------------------------
// wsdb_task_ram
// Single-port task word store with registered read data.
// ----------------------------------------------------------------------------
module wsdb_task_ram #(
  parameter int ADDR_BITS = 9,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [DATA_BITS-1:0] wdata,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/work_stealing_deque_bank.sv
// ----------------------------------------------------------------------------
// work_stealing_deque_bank
// One bounded task deque per worker: push and pop at the top of a worker's
// own deque, steal from the bottom of the lowest non-empty active deque.
// ----------------------------------------------------------------------------
//  channel | signals                    | direction | beat
//  --------+----------------------------+-----------+------------------------
//  req     | req_valid req_ready req    | in        | opcode, worker, task
//  rsp     | rsp_valid rsp_ready rsp    | out       | status, task, source
//  cfg     | cfg_valid cfg_ready cfg_data | in      | active_workers
//
// each request passes through S_IDLE, where the accept cycle decides from the pointer
// registers and addresses the task ram, and S_RESULT, which forms the result from
// the registered ram read data once the output is free. a result held by rsp_ready does not stop the
// next request from being accepted; only a second pending result stalls.
// reset clears pointers and counts; the ram is not cleared.
module work_stealing_deque_bank #(
  parameter int QUEUES = wsdb_pkg::QUEUES_DEF,
  parameter int DEPTH  = wsdb_pkg::DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  wsdb_pkg::req_t         req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output wsdb_pkg::rsp_t         rsp,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [wsdb_pkg::CFG_BITS-1:0] cfg_data
);

  import wsdb_pkg::*;

  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AB = QW + PW;
  localparam int EW = ($clog2(QUEUES + 1) > CFG_BITS) ? $clog2(QUEUES + 1) : CFG_BITS;

  typedef enum logic {S_IDLE, S_RESULT} state_t;

  state_t                 state;
  logic [CFG_BITS-1:0]    active_workers;
  logic [PW-1:0]          top_ptr [QUEUES];
  logic [PW-1:0]          bot_ptr [QUEUES];
  logic [CW-1:0]          count   [QUEUES];

  status_t                pend_status;
  logic [WORKER_BITS-1:0] pend_src;
  logic                   pend_mem;

  logic [EW-1:0]          eff_act;
  logic [QW-1:0]          own_q;
  logic                   own_ok;
  logic [CW-1:0]          own_count;
  logic                   steal_hit;
  logic [QW-1:0]          steal_q;
  logic [PW-1:0]          top_prev;

  status_t                dec_status;
  logic [WORKER_BITS-1:0] dec_src;
  logic                   mem_en;
  logic                   mem_we;
  logic [AB-1:0]          mem_addr;
  logic [TASK_BITS-1:0]   mem_rdata;
  logic                   accept;
  logic                   out_free;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
  endfunction

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  // register value 0 acts as 1, values above the bank size clamp
  always_comb begin
    if (active_workers == '0) begin
      eff_act = EW'(1);
    end else if (EW'(active_workers) > EW'(QUEUES)) begin
      eff_act = EW'(QUEUES);
    end else begin
      eff_act = EW'(active_workers);
    end
  end

  assign own_q     = QW'(req.worker);
  assign own_ok    = EW'(req.worker) < eff_act;
  assign own_count = count[own_q];
  assign top_prev  = ring_prev(top_ptr[own_q]);

  // lowest-numbered non-empty active deque
  always_comb begin
    steal_hit = 1'b0;
    steal_q   = '0;
    for (int j = QUEUES - 1; j >= 0; j--) begin
      if ((EW'(j) < eff_act) && (count[j] != '0)) begin
        steal_hit = 1'b1;
        steal_q   = QW'(j);
      end
    end
  end

  always_comb begin
    dec_status = ST_BAD;
    dec_src    = '0;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = {own_q, top_ptr[own_q]};
    if (own_ok) begin
      dec_src = req.worker;
      if (req.opcode == OP_PUSH) begin
        if (own_count == CW'(DEPTH)) begin
          dec_status = ST_FULL;
        end else begin
          dec_status = ST_PUSHED;
          mem_en     = accept;
          mem_we     = 1'b1;
        end
      end else if (own_count != '0) begin
        dec_status = ST_OWN;
        mem_en     = accept;
        mem_addr   = {own_q, top_prev};
      end else if (steal_hit) begin
        dec_status = ST_STOLEN;
        dec_src    = WORKER_BITS'(steal_q);
        mem_en     = accept;
        mem_addr   = {steal_q, bot_ptr[steal_q]};
      end else begin
        dec_status = ST_NONE;
      end
    end
  end

  wsdb_task_ram #(
    .ADDR_BITS (AB),
    .DATA_BITS (TASK_BITS)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (req.task_word),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      active_workers <= CFG_BITS'(ACTIVE_RESET);
      rsp_valid      <= 1'b0;
      for (int q = 0; q < QUEUES; q++) begin
        top_ptr[q] <= '0;
        bot_ptr[q] <= '0;
        count[q]   <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_workers <= cfg_data;
      end
      // in S_RESULT the output load below owns rsp_valid
      if (rsp_valid && rsp_ready && (state != S_RESULT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend_status <= dec_status;
            pend_src    <= dec_src;
            pend_mem    <= (dec_status == ST_OWN) || (dec_status == ST_STOLEN);
            state       <= S_RESULT;
            unique case (dec_status)
              ST_PUSHED: begin
                top_ptr[own_q] <= ring_next(top_ptr[own_q]);
                count[own_q]   <= own_count + CW'(1);
              end
              ST_OWN: begin
                top_ptr[own_q] <= top_prev;
                count[own_q]   <= own_count - CW'(1);
              end
              ST_STOLEN: begin
                bot_ptr[steal_q] <= ring_next(bot_ptr[steal_q]);
                count[steal_q]   <= count[steal_q] - CW'(1);
              end
              default: begin
              end
            endcase
          end
        end
        S_RESULT: begin
          // ram read data holds until the next request is accepted
          if (out_free) begin
            rsp_valid        <= 1'b1;
            rsp.status       <= pend_status;
            rsp.task_out     <= pend_mem ? mem_rdata : '0;
            rsp.source_queue <= pend_src;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the work-stealing deque bank. A short table of
// directed beats covers reset state, field extremes, both operations,
// out-of-range worker counts, hidden deques and steals. Random phases follow,
// with push and take bursts, full-deque fills and random noise. Every accepted
// request runs through a local deque model, and each result beat is compared
// field by field with the oldest expected one, under varying sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wsdb_pkg::*;

  localparam int QUEUES      = QUEUES_DEF;
  localparam int DEPTH       = DEPTH_DEF;
  localparam int PTR_BITS    = $clog2(DEPTH);
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_PAUSE = 4;

  typedef struct {
    bit                  is_cfg;
    logic [CFG_BITS-1:0] cfg_value;
    req_t                beat;
    bit                  typed;
    rsp_t                want;
  } plan_row_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  req_t                req       = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  rsp_t                rsp;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data  = '0;

  // local deque model
  logic [TASK_BITS-1:0] task_ram [QUEUES][DEPTH];
  logic [PTR_BITS-1:0]  top_ptr  [QUEUES];
  logic [PTR_BITS-1:0]  bot_ptr  [QUEUES];
  int unsigned          fill     [QUEUES];
  logic [CFG_BITS-1:0]  active_cfg = CFG_BITS'(ACTIVE_RESET);

  rsp_t        awaited_results[$];
  plan_row_t   directed_plan[$];
  rsp_t        oldest;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned holds_asked    = 0;
  int unsigned holds_done     = 0;

  work_stealing_deque_bank i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned active_count();
    if (active_cfg == 0) return 1;
    if (active_cfg > QUEUES) return QUEUES;
    return active_cfg;
  endfunction

  function automatic rsp_t predict_deque_op(input req_t beat);
    rsp_t        res;
    int unsigned act;
    bit          found;
    act              = active_count();
    found            = 1'b0;
    res.status       = ST_NONE;
    res.task_out     = '0;
    res.source_queue = beat.worker;
    if (beat.worker >= act) begin
      res.status       = ST_BAD;
      res.source_queue = '0;
    end else if (beat.opcode == OP_PUSH) begin
      if (fill[beat.worker] >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        task_ram[beat.worker][top_ptr[beat.worker]] = beat.task_word;
        top_ptr[beat.worker] = top_ptr[beat.worker] + PTR_BITS'(1);
        fill[beat.worker]++;
        res.status = ST_PUSHED;
      end
    end else if (fill[beat.worker] != 0) begin
      top_ptr[beat.worker] = top_ptr[beat.worker] - PTR_BITS'(1);
      fill[beat.worker]--;
      res.task_out = task_ram[beat.worker][top_ptr[beat.worker]];
      res.status   = ST_OWN;
    end else begin
      // steal from the bottom of the lowest non-empty active deque
      for (int j = 0; j < act; j++) begin
        if (!found && fill[j] != 0) begin
          found            = 1'b1;
          res.task_out     = task_ram[j][bot_ptr[j]];
          bot_ptr[j]       = bot_ptr[j] + PTR_BITS'(1);
          fill[j]--;
          res.status       = ST_STOLEN;
          res.source_queue = WORKER_BITS'(j);
        end
      end
    end
    return res;
  endfunction

  function automatic plan_row_t op_row(input logic op, input logic [WORKER_BITS-1:0] w,
                                       input logic [TASK_BITS-1:0] word);
    plan_row_t row;
    row.is_cfg         = 1'b0;
    row.cfg_value      = '0;
    row.beat.opcode    = op;
    row.beat.worker    = w;
    row.beat.task_word = word;
    row.typed          = 1'b0;
    row.want           = '0;
    return row;
  endfunction

  function automatic plan_row_t known_row(input logic op, input logic [WORKER_BITS-1:0] w,
                                          input logic [TASK_BITS-1:0] word, input status_t st,
                                          input logic [TASK_BITS-1:0] task_val,
                                          input logic [WORKER_BITS-1:0] src);
    plan_row_t row;
    row                   = op_row(op, w, word);
    row.typed             = 1'b1;
    row.want.status       = st;
    row.want.task_out     = task_val;
    row.want.source_queue = src;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_BITS-1:0] value);
    plan_row_t row;
    row           = op_row(OP_PUSH, '0, '0);
    row.is_cfg    = 1'b1;
    row.cfg_value = value;
    return row;
  endfunction

  // offers one request beat and books its expected result on acceptance
  task automatic send_req(input req_t beat, input bit typed, input rsp_t want);
    rsp_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= beat;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    got = predict_deque_op(beat);
    awaited_results.push_back(typed ? want : got);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_active(input logic [CFG_BITS-1:0] value);
    wait_drained();
    repeat (DRAIN_PAUSE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    active_cfg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned rsp_stall,
                           input logic [CFG_BITS-1:0] act_value, input int unsigned items,
                           input bit fill_first, input bit hold_mid, input bit drain_mid);
    req_t                   beat;
    int unsigned            sent;
    int unsigned            len;
    int unsigned            pick;
    bit                     mid_done;
    logic [WORKER_BITS-1:0] w;
    write_active(act_value);
    send_idle_pct = idle_pct;
    stall_pct     = rsp_stall;
    sent          = 0;
    mid_done      = 1'b0;
    while (sent < items) begin
      pick = (fill_first && sent == 0) ? 0 : $urandom_range(0, 99);
      w    = WORKER_BITS'($urandom_range(0, active_count() - 1));
      len  = (pick < 3) ? DEPTH + 2 : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        beat.task_word = $urandom();
        if (pick < 35) begin
          beat.opcode = OP_PUSH;
          beat.worker = w;
        end else if (pick < 70) begin
          beat.opcode = OP_TAKE;
          beat.worker = w;
        end else begin
          // noise: any operation from any worker, active or not
          beat.opcode = 1'($urandom_range(0, 1));
          beat.worker = WORKER_BITS'($urandom_range(0, 7));
        end
        send_req(beat, 1'b0, '0);
      end
      sent += len;
      if (!mid_done && sent >= items / 2) begin
        mid_done = 1'b1;
        if (hold_mid) holds_asked++;
        if (drain_mid) wait_drained();
      end
    end
  endtask

  // receiver: random stalls, plus a long hold-off when one is asked for
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d task_out %h source_queue %0d",
               rsp.status, rsp.task_out, rsp.source_queue);
        mismatch_count++;
      end else begin
        oldest = awaited_results.pop_front();
        if (rsp.status !== oldest.status) begin
          $error("status: expected %0d, actual %0d", oldest.status, rsp.status);
          mismatch_count++;
        end
        if (rsp.task_out !== oldest.task_out) begin
          $error("task_out: expected %h, actual %h", oldest.task_out, rsp.task_out);
          mismatch_count++;
        end
        if (rsp.source_queue !== oldest.source_queue) begin
          $error("source_queue: expected %0d, actual %0d", oldest.source_queue,
                 rsp.source_queue);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int q = 0; q < QUEUES; q++) begin
      top_ptr[q] = '0;
      bot_ptr[q] = '0;
      fill[q]    = 0;
    end

    // directed beats
    directed_plan.push_back(known_row(OP_TAKE, 3'd0, 32'h0, ST_NONE, 32'h0, 3'd0));
    directed_plan.push_back(known_row(OP_TAKE, 3'd7, 32'hFFFF_FFFF, ST_NONE, 32'h0, 3'd7));
    directed_plan.push_back(known_row(OP_PUSH, 3'd0, 32'h0, ST_PUSHED, 32'h0, 3'd0));
    directed_plan.push_back(known_row(OP_PUSH, 3'd0, 32'hFFFF_FFFF, ST_PUSHED, 32'h0, 3'd0));
    directed_plan.push_back(known_row(OP_PUSH, 3'd7, 32'hA5A5_5A5A, ST_PUSHED, 32'h0, 3'd7));
    directed_plan.push_back(known_row(OP_TAKE, 3'd0, 32'h0, ST_OWN, 32'hFFFF_FFFF, 3'd0));
    directed_plan.push_back(op_row(OP_TAKE, 3'd3, 32'h0));
    directed_plan.push_back(op_row(OP_TAKE, 3'd3, 32'h0));
    directed_plan.push_back(op_row(OP_TAKE, 3'd5, 32'h0));
    // zero workers behaves as one
    directed_plan.push_back(cfg_row(4'd0));
    directed_plan.push_back(known_row(OP_TAKE, 3'd1, 32'h0, ST_BAD, 32'h0, 3'd0));
    directed_plan.push_back(known_row(OP_PUSH, 3'd0, 32'h1234_5678, ST_PUSHED, 32'h0, 3'd0));
    directed_plan.push_back(known_row(OP_PUSH, 3'd7, 32'hDEAD_BEEF, ST_BAD, 32'h0, 3'd0));
    // above the deque count behaves as all deques
    directed_plan.push_back(cfg_row(4'd15));
    directed_plan.push_back(op_row(OP_PUSH, 3'd7, 32'h8000_0001));
    directed_plan.push_back(op_row(OP_PUSH, 3'd6, 32'h7FFF_FFFE));
    // shrink: deques 6 and 7 keep entries but are out of reach
    directed_plan.push_back(cfg_row(4'd3));
    directed_plan.push_back(op_row(OP_TAKE, 3'd0, 32'h0));
    directed_plan.push_back(op_row(OP_TAKE, 3'd0, 32'h0));
    directed_plan.push_back(known_row(OP_TAKE, 3'd6, 32'h0, ST_BAD, 32'h0, 3'd0));
    directed_plan.push_back(cfg_row(4'd8));
    directed_plan.push_back(op_row(OP_TAKE, 3'd2, 32'h0));
    directed_plan.push_back(op_row(OP_TAKE, 3'd2, 32'h0));
    directed_plan.push_back(op_row(OP_PUSH, 3'd4, 32'h5555_5555));
    directed_plan.push_back(op_row(OP_TAKE, 3'd4, 32'h0));
    directed_plan.push_back(op_row(OP_TAKE, 3'd4, 32'h0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        write_active(directed_plan[i].cfg_value);
      end else begin
        send_req(directed_plan[i].beat, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    run_phase(0, 0, 4'd8, 190, 1'b1, 1'b1, 1'b0);
    run_phase(68, 0, 4'd5, 180, 1'b0, 1'b0, 1'b1);
    run_phase(0, 68, 4'd1, 180, 1'b1, 1'b0, 1'b0);
    run_phase(38, 38, 4'd7, 180, 1'b0, 1'b0, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/wsdb_pkg.sv
rtl/wsdb_task_ram.sv
rtl/work_stealing_deque_bank.sv
dv/tb_top.sv
